// ===== rtl/sxg_pkg.sv =====
// Shared constants and types for the 3x3 horizontal Sobel gradient unit.
`timescale 1ns / 1ps

package sxg_pkg;

   // Widest supported frame row; sets the depth of the line memory.
   localparam int MAX_WIDTH  = 8192;
   localparam int MAX_HEIGHT = 8192;

   localparam int PIX_W = 8;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int DIM_W = 14;
   localparam int OUT_W = 13;

   localparam int CSR_DW  = 32;
   localparam int CSR_AW  = 3;
   localparam int CSR_IDX_W = CSR_AW - 2;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = CSR_IDX_W'(1);

   localparam logic [DIM_W-1:0] FRAME_WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RESET = DIM_W'(480);
   localparam logic [DIM_W-1:0] DIM_MIN            = DIM_W'(3);

   // Position of one request in the frame and what it produces.
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             produce;
      logic             frame_end;
   } pos_type;

endpackage

// ===== rtl/sxg_pos_counter.sv =====
// Raster position tracker: row and column of each request, with frame wrap.
`timescale 1ns / 1ps

module sxg_pos_counter
   import sxg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic [DIM_W-1:0] frame_width,
   input  logic [DIM_W-1:0] frame_height,
   output pos_type          pos
);

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [DIM_W-1:0] w_eff, h_eff;
   logic             pre_wrap;
   logic [DIM_W-1:0] row_pre;
   logic [COL_W-1:0] cur_col;
   logic [ROW_W-1:0] cur_row;
   logic             last_col, last_row;

   always_comb begin
      if (frame_width < DIM_MIN) begin
         w_eff = DIM_MIN;
      end else if (frame_width > DIM_W'(MAX_WIDTH)) begin
         w_eff = DIM_W'(MAX_WIDTH);
      end else begin
         w_eff = frame_width;
      end
      if (frame_height < DIM_MIN) begin
         h_eff = DIM_MIN;
      end else if (frame_height > DIM_W'(MAX_HEIGHT)) begin
         h_eff = DIM_W'(MAX_HEIGHT);
      end else begin
         h_eff = frame_height;
      end
   end

   // A dimension shrunk mid-frame can leave the stored position outside the
   // frame; it is folded back before use.
   always_comb begin
      pre_wrap = DIM_W'(col_ff) >= w_eff;
      cur_col  = pre_wrap ? '0 : col_ff;
      row_pre  = DIM_W'(row_ff) + DIM_W'(pre_wrap);
      cur_row  = (row_pre >= h_eff) ? '0 : ROW_W'(row_pre);
      last_col = DIM_W'(cur_col) == (w_eff - DIM_W'(1));
      last_row = DIM_W'(cur_row) == (h_eff - DIM_W'(1));

      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : cur_row + ROW_W'(1);
      end else begin
         col_in = cur_col + COL_W'(1);
         row_in = cur_row;
      end

      pos.row       = cur_row;
      pos.col       = cur_col;
      pos.produce   = (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
      pos.frame_end = last_row && last_col;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (advance) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ===== rtl/sxg_datapath.sv =====
// Line memory, 3x3 sliding window and the horizontal gradient arithmetic.
`timescale 1ns / 1ps

module sxg_datapath
   import sxg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_addr,
   input  logic             advance,
   input  logic [COL_W-1:0] wr_addr,
   input  logic [PIX_W-1:0] pixel,
   output logic [PIX_W-1:0] gradient
);

   // Each entry holds {row r-2, row r-1} for one column.
   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] rd_q_ff;
   logic [PIX_W-1:0]   win_ff [6];
   logic [PIX_W-1:0]   top_px, mid_px;

   assign top_px = rd_q_ff[2*PIX_W-1:PIX_W];
   assign mid_px = rd_q_ff[PIX_W-1:0];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_q_ff <= line_mem[rd_addr];
      end
      if (advance) begin
         line_mem[wr_addr] <= {mid_px, pixel};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (advance) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top_px;
         win_ff[4] <= mid_px;
         win_ff[5] <= pixel;
      end
   end

   // Modulo-256 arithmetic, so everything stays eight bits wide.
   assign gradient = win_ff[0] + {win_ff[1][PIX_W-2:0], 1'b0} + win_ff[2]
                   - top_px - {mid_px[PIX_W-2:0], 1'b0} - pixel;

endmodule

// ===== rtl/sobel_x_gradient_3x3_unit.sv =====
// Top level of the streaming 3x3 horizontal Sobel gradient unit.
// An accepted request passes through stage one and then the result register, which drives
// rsp_valid; a held result can keep a producing request waiting in stage one.
// Throughput: one pixel request per cycle; the line memory takes one read at accept and one
// write-back as the request leaves stage one, and the input only stalls while a result waits.
// Reset (synchronous, active high) clears position, window and pipeline valid flags and
// loads frame_width 640 and frame_height 480; the line memory is not cleared.
`timescale 1ns / 1ps

module sobel_x_gradient_3x3_unit
   import sxg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,

   input  logic              req_valid,
   output logic              req_ready,
   input  logic [PIX_W-1:0]  req_pixel,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [PIX_W-1:0]  rsp_gradient,
   output logic [OUT_W-1:0]  rsp_out_row,
   output logic [OUT_W-1:0]  rsp_out_col,
   output logic              rsp_frame_end,

   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   // ---------------------------------------------------------------------
   // Configuration registers. Each register sits at byte address 4*index.
   // ---------------------------------------------------------------------
   logic [DIM_W-1:0]     frame_width_ff, frame_height_ff;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic                 csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_AW-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_FRAME_WIDTH:  frame_width_ff  <= csr_pwdata[DIM_W-1:0];
            REG_FRAME_HEIGHT: frame_height_ff <= csr_pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_FRAME_WIDTH:  csr_prdata = CSR_DW'(frame_width_ff);
         REG_FRAME_HEIGHT: csr_prdata = CSR_DW'(frame_height_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Pipeline control. Stage one holds the accepted pixel and its position
   // while the line memory read completes; the result register decouples
   // the output so a new request can enter while a result waits.
   // ---------------------------------------------------------------------
   logic             req_fire;
   logic             s1_valid_ff;
   logic [PIX_W-1:0] s1_pixel_ff;
   pos_type          s1_pos_ff;
   pos_type          cur_pos;
   logic             out_free;
   logic             s1_advance;
   logic [PIX_W-1:0] gradient;

   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_gradient_ff;
   logic [OUT_W-1:0] rsp_row_ff, rsp_col_ff;
   logic             rsp_frame_end_ff;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   // A request that produces no result leaves stage one without the output.
   assign s1_advance = s1_valid_ff && (!s1_pos_ff.produce || out_free);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_fire   = req_valid && req_ready;

   sxg_pos_counter u_pos (
      .clock        (clock),
      .reset        (reset),
      .advance      (req_fire),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .pos          (cur_pos)
   );

   // Consecutive requests always touch different columns, so the write-back
   // of stage one never collides with the read of the incoming request.
   sxg_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_fire),
      .rd_addr  (cur_pos.col),
      .advance  (s1_advance),
      .wr_addr  (s1_pos_ff.col),
      .pixel    (s1_pixel_ff),
      .gradient (gradient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pixel_ff <= req_pixel;
         s1_pos_ff   <= cur_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance && s1_pos_ff.produce) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Results are tagged with the top-left corner of the window.
   always_ff @(posedge clock) begin
      if (s1_advance && s1_pos_ff.produce) begin
         rsp_gradient_ff  <= gradient;
         rsp_row_ff       <= OUT_W'(s1_pos_ff.row - ROW_W'(2));
         rsp_col_ff       <= OUT_W'(s1_pos_ff.col - COL_W'(2));
         rsp_frame_end_ff <= s1_pos_ff.frame_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_gradient  = rsp_gradient_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // A producing request that leaves stage one must show up as a result.
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && s1_pos_ff.produce) |=> rsp_valid_ff)
      else $error("producing request left stage one without a result");

   // The input only stalls when stage one is blocked by a held result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && s1_pos_ff.produce && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without a blocked result");

   // Only complete windows may be marked as producing a result.
   a_interior_only: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_pos_ff.produce) |->
         (s1_pos_ff.row >= ROW_W'(2) && s1_pos_ff.col >= COL_W'(2)))
      else $error("result requested for an incomplete window");

endmodule
